// File: rtl/i2a_pkg.sv
// package for the integer to ascii converter: widths, codes, transaction
// structs and the digit-to-character function; no dependencies
package i2a_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int IN_VALUE_W  = 32;
  localparam int NCELL       = VALUE_WIDTH;
  localparam int CNT_W       = $clog2(NCELL + 1);
  localparam int IDX_W       = $clog2(NCELL);
  localparam int BIT_W       = $clog2(VALUE_WIDTH);

  localparam logic [1:0] OP_DEC = 2'd0;
  localparam logic [1:0] OP_HEX = 2'd1;
  localparam logic [1:0] OP_BIN = 2'd2;

  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_HEX = 5'd16;
  localparam logic [4:0] RADIX_BIN = 5'd2;
  localparam logic [3:0] HALF_DEC  = 4'd5;

  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_LOW_A = 7'h61;
  localparam logic [6:0] CH_MINUS = 7'h2d;
  localparam logic [6:0] CH_PLUS  = 7'h2b;

  typedef enum logic [1:0] {
    RDX_DEC,
    RDX_HEX,
    RDX_BIN
  } radix_t;

  typedef enum logic [1:0] {
    SGN_NONE,
    SGN_PLUS,
    SGN_MINUS
  } sign_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [1:0]            op;
    logic                  is_signed;
  } in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_t;

  typedef struct packed {
    logic   clr;
    logic   shift;
    radix_t radix;
  } cell_ctrl_t;

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] ch;
    if (d > 4'd9) begin
      ch = CH_LOW_A + {3'd0, d} - 7'd10;
    end else begin
      ch = CH_ZERO + {3'd0, d};
    end
    return ch;
  endfunction

endpackage

// File: rtl/i2a_cell.sv
// one digit cell of the conversion row: doubles its digit and adds the
// carry from below, handing its own carry up; depends on i2a_pkg
module i2a_cell
  import i2a_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       carry_in,
  output logic       carry_out,
  output logic [3:0] digit
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [4:0] dbl;
  logic [4:0] radix_val;

  always_comb begin
    case (ctrl.radix)
      RDX_HEX: begin
        carry_out = digit_r[3];
        radix_val = RADIX_HEX;
      end
      RDX_BIN: begin
        carry_out = digit_r[0];
        radix_val = RADIX_BIN;
      end
      default: begin
        carry_out = (digit_r >= HALF_DEC);
        radix_val = RADIX_DEC;
      end
    endcase
    dbl = {digit_r, carry_in};
    if (carry_out) begin
      digit_nxt = 4'(dbl - radix_val);
    end else begin
      digit_nxt = dbl[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      digit_r <= 4'd0;
    end else if (ctrl.shift) begin
      digit_r <= digit_nxt;
    end
  end

  assign digit = digit_r;

endmodule

// File: rtl/integer_to_ascii_radix.sv
// integer to ascii converter top level: bit-serial radix conversion through
// a row of digit cells, then character output; depends on i2a_pkg, i2a_cell
// steps: the number is accepted, its bits are shifted msb first through the
//   cell row, a sign character follows if signed, then one character per
//   cycle unless the output is stalled; a new number is taken only once the
//   last character of the previous one is loaded into the output register
// reset: rst_n synchronous active low, returns the controller to idle with
//   no transaction pending; digit cells are cleared when a number is taken
module integer_to_ascii_radix
  import i2a_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // controller state
  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BIT_W-1:0]       bitcnt_r, bitcnt_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  sign_t                  sign_r, sign_nxt;
  radix_t                 radix_r, radix_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  // cell row
  cell_ctrl_t      cell_ctrl;
  logic [NCELL:0]  cy;
  logic [3:0]      digits [NCELL];

  logic                   in_acc;
  logic                   out_free;
  logic [VALUE_WIDTH-1:0] in_val;
  logic [CNT_W-1:0]       cnt_grow;
  logic [CNT_W-1:0]       top_idx;
  logic [3:0]             top_digit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // low VALUE_WIDTH bits of the field, zero extended if the field is narrower
  assign in_val = VALUE_WIDTH'({{VALUE_WIDTH{1'b0}}, in_data.value});

  // msb of the magnitude enters the least significant cell
  assign cy[0] = mag_r[VALUE_WIDTH-1];

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    i2a_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .carry_in  (cy[i]),
      .carry_out (cy[i+1]),
      .digit     (digits[i])
    );
  end

  // number of significant cells grows when a carry reaches the first zero cell
  assign cnt_grow  = cnt_r + CNT_W'(cy[cnt_r]);
  assign top_idx   = cnt_r - CNT_W'(1);
  assign top_digit = digits[top_idx[IDX_W-1:0]];

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bitcnt_nxt    = bitcnt_r;
    cnt_nxt       = cnt_r;
    sign_nxt      = sign_r;
    radix_nxt     = radix_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cell_ctrl.clr   = 1'b0;
    cell_ctrl.shift = 1'b0;
    cell_ctrl.radix = radix_r;

    // output slot drains when the receiver takes the transaction
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data.op)
            OP_HEX:  radix_nxt = RDX_HEX;
            OP_BIN:  radix_nxt = RDX_BIN;
            default: radix_nxt = RDX_DEC;
          endcase
          // signed inputs convert their magnitude as unsigned
          if (in_data.is_signed && in_val[VALUE_WIDTH-1]) begin
            sign_nxt = SGN_MINUS;
            mag_nxt  = VALUE_WIDTH'(~in_val + 1'b1);
          end else begin
            sign_nxt = in_data.is_signed ? SGN_PLUS : SGN_NONE;
            mag_nxt  = in_val;
          end
          bitcnt_nxt    = '0;
          cnt_nxt       = '0;
          cell_ctrl.clr = 1'b1;
          state_nxt     = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_ctrl.shift = 1'b1;
        mag_nxt         = mag_r << 1;
        bitcnt_nxt      = bitcnt_r + BIT_W'(1);
        cnt_nxt         = cnt_grow;
        if (bitcnt_r == BIT_W'(VALUE_WIDTH - 1)) begin
          // zero still shows one digit
          if (cnt_grow == '0) begin
            cnt_nxt = CNT_W'(1);
          end
          state_nxt = (sign_r == SGN_NONE) ? ST_EMIT : ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.char_code = (sign_r == SGN_MINUS) ? CH_MINUS : CH_PLUS;
          out_data_nxt.last      = 1'b0;
          sign_nxt               = SGN_NONE;
          state_nxt              = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // most significant digit first, read from the top significant cell
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.char_code = digit_char(top_digit);
          out_data_nxt.last      = (cnt_r == CNT_W'(1));
          cnt_nxt                = top_idx;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      bitcnt_r    <= '0;
      sign_r      <= SGN_NONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      bitcnt_r    <= bitcnt_nxt;
      sign_r      <= sign_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    radix_r    <= radix_nxt;
    out_data_r <= out_data_nxt;
  end

  // significant digit count never exceeds the cell row
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NCELL))
    else $error("digit count beyond cell row");

  // output phase always has at least one digit left
  a_emit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> cnt_r != '0)
    else $error("emit with no digit left");

  // an accepted number starts the shift loop
  a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == ST_CONV)
    else $error("accepted number did not start conversion");

  // the final digit carries the last mark and frees the input side
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && out_free && cnt_r == CNT_W'(1)
      |=> state_r == ST_IDLE && out_valid_r && out_data_r.last)
    else $error("last digit not marked or controller not idle");

endmodule
